### design/closest_points_between_lines_unit_assert.svh
// ----------------------------------------------------------------------------
// Closest points between lines: assertion macros
// Shared property shapes for the checker. Clock clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINTS_BETWEEN_LINES_UNIT_ASSERT_SVH
`define CLOSEST_POINTS_BETWEEN_LINES_UNIT_ASSERT_SVH

// same-cycle implication
`define CPL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpl assertion failed");

// next-cycle implication
`define CPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpl assertion failed");

`endif

### design/cpl_pkg.sv
// ----------------------------------------------------------------------------
// Closest points between lines: package
// Word types, widths of the intermediate terms and register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpl_pkg;

  localparam int CW       = 32;
  localparam int DW       = 16;
  localparam int DIR_FRAC = 12;

  localparam int C_W    = 2 * DW + 1;
  localparam int DEN_W  = 2 * C_W + 2;
  localparam int W_W    = DW + C_W + 1;
  localparam int DIFF_W = CW + 1;
  localparam int DET_W  = DIFF_W + W_W + 2;
  localparam int NUM_W  = DW + DET_W;
  localparam int RW     = NUM_W + 2;

  localparam int CHUNK   = 32;
  localparam int MUL_LAT = 2;

  localparam int RDIV_LAT = CW + 2;
  localparam int LATENCY  = CW + 15;

  localparam int ADDR_W = 3;
  localparam logic CFG_IDX_LIMIT = 1'b0;
  localparam logic [31:0] LIMIT_RESET = 32'd1;

  typedef struct packed {
    logic signed [CW-1:0] first_origin_x;
    logic signed [CW-1:0] first_origin_y;
    logic signed [CW-1:0] first_origin_z;
    logic signed [DW-1:0] first_dir_x;
    logic signed [DW-1:0] first_dir_y;
    logic signed [DW-1:0] first_dir_z;
    logic signed [CW-1:0] second_origin_x;
    logic signed [CW-1:0] second_origin_y;
    logic signed [CW-1:0] second_origin_z;
    logic signed [DW-1:0] second_dir_x;
    logic signed [DW-1:0] second_dir_y;
    logic signed [DW-1:0] second_dir_z;
  } cpl_in_t;

  typedef struct packed {
    logic                 found;
    logic signed [CW-1:0] first_point_x;
    logic signed [CW-1:0] first_point_y;
    logic signed [CW-1:0] first_point_z;
    logic signed [CW-1:0] second_point_x;
    logic signed [CW-1:0] second_point_y;
    logic signed [CW-1:0] second_point_z;
  } cpl_out_t;

endpackage

`default_nettype wire

### design/cpl_mul.sv
// ----------------------------------------------------------------------------
// Closest points between lines: pipelined signed multiplier
// Splits both operands into chunks, registers the partial products, then sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpl_mul import cpl_pkg::*; #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  wire                      clk,
  input  wire  signed [AW-1:0]     a,
  input  wire  signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  localparam int NA = (AW + CHUNK - 1) / CHUNK;
  localparam int NB = (BW + CHUNK - 1) / CHUNK;
  localparam int PW = AW + BW;

  logic signed [NA*CHUNK-1:0]   a_ext;
  logic signed [NB*CHUNK-1:0]   b_ext;
  logic signed [CHUNK:0]        a_ch [NA];
  logic signed [CHUNK:0]        b_ch [NB];
  logic signed [2*CHUNK+1:0]    pp_r [NA][NB];
  logic signed [PW-1:0]         sum_nxt;
  logic signed [PW-1:0]         p_r;

  assign a_ext = (NA*CHUNK)'(a);
  assign b_ext = (NB*CHUNK)'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      a_ch[i] = {(i == NA - 1) ? a_ext[NA*CHUNK-1] : 1'b0, a_ext[i*CHUNK +: CHUNK]};
    end
    for (int j = 0; j < NB; j++) begin
      b_ch[j] = {(j == NB - 1) ? b_ext[NB*CHUNK-1] : 1'b0, b_ext[j*CHUNK +: CHUNK]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= a_ch[i] * b_ch[j];
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (PW'(pp_r[i][j]) <<< ((i + j) * CHUNK));
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= sum_nxt;
  end

  assign p = p_r;

endmodule

`default_nettype wire

### design/cpl_rdiv.sv
// ----------------------------------------------------------------------------
// Closest points between lines: rounding divider and point adder
// One quotient bit per stage, round to nearest with ties away from zero,
// then origin + offset saturated to the coordinate range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpl_rdiv import cpl_pkg::*; (
  input  wire                     clk,
  input  wire  signed [NUM_W-1:0] num,
  input  wire         [DEN_W-1:0] den,
  input  wire  signed [CW-1:0]    org,
  output logic signed [CW-1:0]    pt
);

  localparam logic signed [CW+1:0] PMAX = (CW+2)'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [CW+1:0] PMIN = -PMAX - (CW+2)'(1);

  logic [NUM_W-1:0]     mag;
  logic [RW-1:0]        n2_r;
  logic [RW-1:0]        dd_r;
  logic                 neg_r;
  logic signed [CW-1:0] org_r;

  logic [RW-1:0]        rs_r   [CW];
  logic [RW-1:0]        dds_r  [CW];
  logic [CW-1:0]        qs_r   [CW];
  logic                 negs_r [CW];
  logic                 ovfs_r [CW];
  logic signed [CW-1:0] orgs_r [CW];

  logic signed [CW:0]   off;
  logic signed [CW+1:0] sum;
  logic signed [CW-1:0] pt_nxt;
  logic signed [CW-1:0] pt_r;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_ff @(posedge clk) begin
    neg_r <= num[NUM_W-1];
    n2_r  <= (RW'(mag) << 1) + RW'(den);
    dd_r  <= RW'(den) << 1;
    org_r <= org;
  end

  genvar s;
  generate
    for (s = 0; s < CW; s++) begin : g_stage
      localparam int K = CW - 1 - s;
      logic [RW-1:0] r_in;
      logic [RW-1:0] d_in;
      logic [CW-1:0] q_in;
      logic          n_in;
      logic          o_in;
      logic signed [CW-1:0] g_in;
      logic [RW-1:0] sh;
      logic          ge;

      if (s == 0) begin : g_first
        assign r_in = n2_r;
        assign d_in = dd_r;
        assign q_in = '0;
        assign n_in = neg_r;
        assign o_in = n2_r >= (dd_r << CW);
        assign g_in = org_r;
      end else begin : g_next
        assign r_in = rs_r[s-1];
        assign d_in = dds_r[s-1];
        assign q_in = qs_r[s-1];
        assign n_in = negs_r[s-1];
        assign o_in = ovfs_r[s-1];
        assign g_in = orgs_r[s-1];
      end

      assign sh = d_in << K;
      assign ge = r_in >= sh;

      always_ff @(posedge clk) begin
        rs_r[s]   <= ge ? r_in - sh : r_in;
        qs_r[s]   <= q_in | (CW'(ge) << K);
        dds_r[s]  <= d_in;
        negs_r[s] <= n_in;
        ovfs_r[s] <= o_in;
        orgs_r[s] <= g_in;
      end
    end
  endgenerate

  always_comb begin
    off = negs_r[CW-1] ? -(CW+1)'(qs_r[CW-1]) : (CW+1)'(qs_r[CW-1]);
    sum = (CW+2)'(orgs_r[CW-1]) + (CW+2)'(off);
    if (ovfs_r[CW-1]) begin
      pt_nxt = negs_r[CW-1] ? CW'(PMIN) : CW'(PMAX);
    end else if (sum > PMAX) begin
      pt_nxt = CW'(PMAX);
    end else if (sum < PMIN) begin
      pt_nxt = CW'(PMIN);
    end else begin
      pt_nxt = CW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

  assign pt = pt_r;

endmodule

`default_nettype wire

### design/closest_points_between_lines_unit.sv
// Valid path: an accepted start enters the valid line v_r, and out_valid is registered from its last stage.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The rate is set by the fully pipelined multipliers and the 32-stage divider.
// Reset (rst_n low, synchronous) clears all valid bits and sets the limit register limit_r to 1.
// ----------------------------------------------------------------------------
// Closest points between lines: top level
// Cross products, determinants, rounding division and saturation in a pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module closest_points_between_lines_unit import cpl_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  cpl_in_t     in_data,
  output logic              out_valid,
  output cpl_out_t          out_data,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [ADDR_W-1:0] paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int OLEN = 11;
  localparam int DLEN = 9;
  localparam int FLEN = CW + 6;
  localparam int VLEN = CW + 14;

  logic [31:0] limit_r;
  cpl_in_t     in_r;
  logic        v_r [VLEN];

  logic signed [CW-1:0]     o1l_r [OLEN][3];
  logic signed [CW-1:0]     o2l_r [OLEN][3];
  logic signed [DW-1:0]     d1l_r [DLEN][3];
  logic signed [DW-1:0]     d2l_r [DLEN][3];
  logic signed [DW-1:0]     d1_in [3];
  logic signed [DW-1:0]     d2_in [3];
  logic signed [CW-1:0]     o1_in [3];
  logic signed [CW-1:0]     o2_in [3];

  logic signed [2*DW-1:0]       pa [3];
  logic signed [2*DW-1:0]       pb [3];
  logic signed [C_W-1:0]        c_r [3];
  logic signed [DIFF_W-1:0]     diff_r [3];
  logic signed [DIFF_W-1:0]     diffl_r [3][3];
  logic signed [2*C_W-1:0]      cc [3];
  logic signed [DW+C_W-1:0]     w1a [3];
  logic signed [DW+C_W-1:0]     w1b [3];
  logic signed [DW+C_W-1:0]     w2a [3];
  logic signed [DW+C_W-1:0]     w2b [3];
  logic         [DEN_W-1:0]     den_r;
  logic         [DEN_W-1:0]     denl_r [5];
  logic signed [W_W-1:0]        w1_r [3];
  logic signed [W_W-1:0]        w2_r [3];
  logic signed [DIFF_W+W_W-1:0] e1 [3];
  logic signed [DIFF_W+W_W-1:0] e2 [3];
  logic signed [DET_W-1:0]      det1_r;
  logic signed [DET_W-1:0]      det2_r;
  logic signed [NUM_W-1:0]      n1 [3];
  logic signed [NUM_W-1:0]      n2 [3];
  logic signed [CW-1:0]         p1 [3];
  logic signed [CW-1:0]         p2 [3];
  logic                         found_r;
  logic                         fl_r [FLEN];
  logic         [DEN_W-1:0]     lim_ext;
  logic                         cfg_wr;

  logic                         out_valid_r;
  cpl_out_t                     out_r;
  cpl_out_t                     out_nxt;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_LIMIT);
  assign prdata = (paddr[2] == CFG_IDX_LIMIT) ? limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata;
    end
  end

  // input capture and valid line
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VLEN; i++) v_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_r[0] <= start && !busy;
      for (int i = 1; i < VLEN; i++) v_r[i] <= v_r[i-1];
      out_valid_r <= v_r[VLEN-1];
    end
  end

  assign o1_in[0] = in_r.first_origin_x;
  assign o1_in[1] = in_r.first_origin_y;
  assign o1_in[2] = in_r.first_origin_z;
  assign o2_in[0] = in_r.second_origin_x;
  assign o2_in[1] = in_r.second_origin_y;
  assign o2_in[2] = in_r.second_origin_z;
  assign d1_in[0] = in_r.first_dir_x;
  assign d1_in[1] = in_r.first_dir_y;
  assign d1_in[2] = in_r.first_dir_z;
  assign d2_in[0] = in_r.second_dir_x;
  assign d2_in[1] = in_r.second_dir_y;
  assign d2_in[2] = in_r.second_dir_z;

  // carry lines for origins and directions
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      o1l_r[0][k] <= o1_in[k];
      o2l_r[0][k] <= o2_in[k];
      d1l_r[0][k] <= d1_in[k];
      d2l_r[0][k] <= d2_in[k];
      for (int i = 1; i < OLEN; i++) begin
        o1l_r[i][k] <= o1l_r[i-1][k];
        o2l_r[i][k] <= o2l_r[i-1][k];
      end
      for (int i = 1; i < DLEN; i++) begin
        d1l_r[i][k] <= d1l_r[i-1][k];
        d2l_r[i][k] <= d2l_r[i-1][k];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_axis
      localparam int J = (g + 1) % 3;
      localparam int K = (g + 2) % 3;

      // c = d1 x d2
      cpl_mul #(.AW(DW), .BW(DW)) u_pa (.clk(clk), .a(d1_in[J]), .b(d2_in[K]), .p(pa[g]));
      cpl_mul #(.AW(DW), .BW(DW)) u_pb (.clk(clk), .a(d1_in[K]), .b(d2_in[J]), .p(pb[g]));

      always_ff @(posedge clk) begin
        c_r[g]        <= C_W'(pa[g]) - C_W'(pb[g]);
        diff_r[g]     <= DIFF_W'(o2l_r[1][g]) - DIFF_W'(o1l_r[1][g]);
        diffl_r[0][g] <= diff_r[g];
        diffl_r[1][g] <= diffl_r[0][g];
        diffl_r[2][g] <= diffl_r[1][g];
      end

      // den terms and w1 = d1 x c, w2 = d2 x c
      cpl_mul #(.AW(C_W), .BW(C_W)) u_cc (.clk(clk), .a(c_r[g]), .b(c_r[g]), .p(cc[g]));
      cpl_mul #(.AW(DW), .BW(C_W)) u_w1a (.clk(clk), .a(d1l_r[2][J]), .b(c_r[K]), .p(w1a[g]));
      cpl_mul #(.AW(DW), .BW(C_W)) u_w1b (.clk(clk), .a(d1l_r[2][K]), .b(c_r[J]), .p(w1b[g]));
      cpl_mul #(.AW(DW), .BW(C_W)) u_w2a (.clk(clk), .a(d2l_r[2][J]), .b(c_r[K]), .p(w2a[g]));
      cpl_mul #(.AW(DW), .BW(C_W)) u_w2b (.clk(clk), .a(d2l_r[2][K]), .b(c_r[J]), .p(w2b[g]));

      always_ff @(posedge clk) begin
        w1_r[g] <= W_W'(w1a[g]) - W_W'(w1b[g]);
        w2_r[g] <= W_W'(w2a[g]) - W_W'(w2b[g]);
      end

      // determinant terms
      cpl_mul #(.AW(DIFF_W), .BW(W_W)) u_e1 (.clk(clk), .a(diffl_r[2][g]), .b(w2_r[g]),
                                             .p(e1[g]));
      cpl_mul #(.AW(DIFF_W), .BW(W_W)) u_e2 (.clk(clk), .a(diffl_r[2][g]), .b(w1_r[g]),
                                             .p(e2[g]));

      // numerators d * det
      cpl_mul #(.AW(DW), .BW(DET_W)) u_n1 (.clk(clk), .a(d1l_r[8][g]), .b(det1_r), .p(n1[g]));
      cpl_mul #(.AW(DW), .BW(DET_W)) u_n2 (.clk(clk), .a(d2l_r[8][g]), .b(det2_r), .p(n2[g]));

      cpl_rdiv u_div1 (.clk(clk), .num(n1[g]), .den(denl_r[4]), .org(o1l_r[10][g]),
                       .pt(p1[g]));
      cpl_rdiv u_div2 (.clk(clk), .num(n2[g]), .den(denl_r[4]), .org(o2l_r[10][g]),
                       .pt(p2[g]));
    end
  endgenerate

  assign lim_ext = DEN_W'({limit_r, {(2*DIR_FRAC){1'b0}}});

  always_ff @(posedge clk) begin
    den_r     <= DEN_W'(cc[0]) + DEN_W'(cc[1]) + DEN_W'(cc[2]);
    denl_r[0] <= den_r;
    for (int i = 1; i < 5; i++) denl_r[i] <= denl_r[i-1];
    found_r   <= den_r > lim_ext;
    fl_r[0]   <= found_r;
    for (int i = 1; i < FLEN; i++) fl_r[i] <= fl_r[i-1];
    det1_r    <= DET_W'(e1[0]) + DET_W'(e1[1]) + DET_W'(e1[2]);
    det2_r    <= DET_W'(e2[0]) + DET_W'(e2[1]) + DET_W'(e2[2]);
  end

  always_comb begin
    out_nxt = '0;
    if (fl_r[FLEN-1]) begin
      out_nxt.found          = 1'b1;
      out_nxt.first_point_x  = p1[0];
      out_nxt.first_point_y  = p1[1];
      out_nxt.first_point_z  = p1[2];
      out_nxt.second_point_x = p2[0];
      out_nxt.second_point_y = p2[1];
      out_nxt.second_point_z = p2[2];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### design/cpl_checker.sv
// ----------------------------------------------------------------------------
// Closest points between lines: port checker
// Watches the top level's ports for latency, rejection and register behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "closest_points_between_lines_unit_assert.svh"

module cpl_checker import cpl_pkg::*; (
  input wire              clk,
  input wire              rst_n,
  input wire              start,
  input wire              busy,
  input wire              out_valid,
  input wire cpl_out_t    out_data,
  input wire              psel,
  input wire              penable,
  input wire              pwrite,
  input wire [ADDR_W-1:0] paddr,
  input wire [31:0]       pwdata,
  input wire [31:0]       prdata,
  input wire              pready
);

  logic lim_sel;
  logic lim_wr;

  assign lim_sel = paddr[2] == CFG_IDX_LIMIT;
  assign lim_wr  = psel && penable && pwrite && lim_sel;

  `CPL_ASSERT_NOW(a_never_busy, 1'b1, !busy && pready)
  `CPL_ASSERT_NOW(a_word_latency, out_valid, $past(start, LATENCY))
  `CPL_ASSERT_NOW(a_reject_zero, out_valid && !out_data.found, out_data[6*CW-1:0] == '0)
  `CPL_ASSERT_NEXT(a_limit_readback, lim_wr, !lim_sel || prdata == $past(pwdata))

endmodule

bind closest_points_between_lines_unit cpl_checker u_cpl_checker (.*);

`default_nettype wire
